@@ rtl/swhfe_pkg.sv @@
// Shared types, constants and helpers for the sync word header field extractor.
package swhfe_pkg;

  localparam int unsigned POS_W      = 31;
  localparam logic [POS_W-1:0] POS_LIMIT = 31'h7FFF_FFFF;
  localparam int unsigned NUM_FIELDS = 3;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 32;
  localparam logic [31:0] SYNC_RESET = 32'hDEAD_BEEF;
  localparam logic [31:0] MASK_BYTE1 = 32'h0000_FF00;
  localparam logic [31:0] MASK_BYTE2 = 32'h00FF_0000;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SYNC_WORD  = 3'd0,
    REG_BIG_ENDIAN = 3'd1,
    REG_A_OFFSET   = 3'd2,
    REG_A_TYPE     = 3'd3,
    REG_B_OFFSET   = 3'd4,
    REG_B_TYPE     = 3'd5,
    REG_C_OFFSET   = 3'd6,
    REG_C_TYPE     = 3'd7
  } reg_idx_e;

  // Field type codes
  localparam logic [3:0] TYPE_S8  = 4'd1;
  localparam logic [3:0] TYPE_U64 = 4'd8;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       stream_start;
  } in_word_t;

  typedef struct packed {
    logic [POS_W-1:0] sync_position;
    logic [1:0]       field_index;
    logic             field_valid;
    logic [63:0]      field_value;
    logic             record_last;
  } out_word_t;

  // Decoded configuration handed to the datapath
  typedef struct packed {
    logic [31:0]                     pattern;
    logic                            big;
    logic [NUM_FIELDS-1:0]           en;
    logic [NUM_FIELDS-1:0]           sgn;
    logic [NUM_FIELDS-1:0][1:0]      wlog;
    logic [NUM_FIELDS-1:0][7:0]      off;
    logic [7:0]                      span;
    logic [7:0]                      neg_earliest;
  } cfg_t;

  function automatic logic [31:0] swap32(input logic [31:0] v);
    return (v >> 24) | ((v >> 8) & MASK_BYTE1) | ((v << 8) & MASK_BYTE2) | (v << 24);
  endfunction

  function automatic logic type_en(input logic [3:0] t);
    return (t >= TYPE_S8) && (t <= TYPE_U64);
  endfunction

  // log2 of the byte width, valid for enabled codes only
  function automatic logic [1:0] type_wlog(input logic [3:0] t);
    logic [3:0] m;
    m = t - TYPE_S8;
    return m[2:1];
  endfunction

endpackage

@@ rtl/swhfe_cfg.sv @@
// Configuration registers and the derived record span and earliest offset.
module swhfe_cfg #(
  parameter int unsigned FieldCount = 3
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 we_i,
  input  logic [swhfe_pkg::CFG_IDX_W-1:0]      idx_i,
  input  logic [swhfe_pkg::CFG_DATA_W-1:0]     data_i,
  output swhfe_pkg::cfg_t                      cfg_o
);

  logic [31:0]     sync_q;
  logic            big_q;
  logic [2:0][7:0] off_q;
  logic [2:0][3:0] typ_q;

  // Register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sync_q <= swhfe_pkg::SYNC_RESET;
      big_q  <= 1'b1;
      off_q  <= '0;
      typ_q  <= '0;
    end else if (we_i) begin
      unique case (swhfe_pkg::reg_idx_e'(idx_i))
        swhfe_pkg::REG_SYNC_WORD:  sync_q   <= data_i[31:0];
        swhfe_pkg::REG_BIG_ENDIAN: big_q    <= data_i[0];
        swhfe_pkg::REG_A_OFFSET:   off_q[0] <= data_i[7:0];
        swhfe_pkg::REG_A_TYPE:     typ_q[0] <= data_i[3:0];
        swhfe_pkg::REG_B_OFFSET:   off_q[1] <= data_i[7:0];
        swhfe_pkg::REG_B_TYPE:     typ_q[1] <= data_i[3:0];
        swhfe_pkg::REG_C_OFFSET:   off_q[2] <= data_i[7:0];
        swhfe_pkg::REG_C_TYPE:     typ_q[2] <= data_i[3:0];
        default:                   sync_q   <= sync_q;
      endcase
    end
  end

  // Decode: enables, widths, record end span and earliest field start
  always_comb begin
    logic signed [9:0] fend;
    logic signed [9:0] mx;
    logic signed [8:0] mn;
    logic [3:0]        w4;
    cfg_o         = '0;
    cfg_o.pattern = big_q ? sync_q : swhfe_pkg::swap32(sync_q);
    cfg_o.big     = big_q;
    mx = 10'sd4;
    mn = 9'sd0;
    for (int i = 0; i < 3; i++) begin
      cfg_o.en[i]   = (i < FieldCount) && swhfe_pkg::type_en(typ_q[i]);
      cfg_o.sgn[i]  = typ_q[i][0];
      cfg_o.wlog[i] = swhfe_pkg::type_wlog(typ_q[i]);
      cfg_o.off[i]  = off_q[i];
      w4   = 4'b0001 << cfg_o.wlog[i];
      fend = 10'sd4 + $signed({{2{off_q[i][7]}}, off_q[i]}) + $signed({6'b0, w4});
      if (cfg_o.en[i] && (fend > mx)) mx = fend;
      if (cfg_o.en[i] && ($signed({off_q[i][7], off_q[i]}) < mn)) begin
        mn = $signed({off_q[i][7], off_q[i]});
      end
    end
    cfg_o.span         = mx[7:0];
    cfg_o.neg_earliest = 8'(-mn);
  end

endmodule

@@ rtl/swhfe_mem.sv @@
// Byte window memory and sync mark memory, both with registered reads.
module swhfe_mem #(
  parameter int unsigned Depth = 512,
  parameter int unsigned AW    = 9
) (
  input  logic          clk_i,
  input  logic          win_we_i,
  input  logic [AW-1:0] win_waddr_i,
  input  logic [7:0]    win_wdata_i,
  input  logic [AW-1:0] win_raddr_i,
  output logic [7:0]    win_rdata_o,
  input  logic          mark_we_i,
  input  logic [AW-1:0] mark_waddr_i,
  input  logic          mark_wbit_i,
  input  logic [AW-1:0] mark_raddr_i,
  output logic          mark_rbit_o
);

  logic [7:0] win_mem  [Depth];
  logic       mark_mem [Depth];
  logic [7:0] win_rdata_q;
  logic       mark_rbit_q;

  // Byte window
  always_ff @(posedge clk_i) begin
    if (win_we_i) win_mem[win_waddr_i] <= win_wdata_i;
    win_rdata_q <= win_mem[win_raddr_i];
  end

  // Pending sync marks, one per window slot
  always_ff @(posedge clk_i) begin
    if (mark_we_i) mark_mem[mark_waddr_i] <= mark_wbit_i;
    mark_rbit_q <= mark_mem[mark_raddr_i];
  end

  assign win_rdata_o = win_rdata_q;
  assign mark_rbit_o = mark_rbit_q;

endmodule

@@ rtl/sync_word_header_field_extractor.sv @@
// Top level: sync word search over a byte stream with header field extraction.
//
// Input channel (in_valid_i / in_stall_o / in_word_i) takes one stream byte per
// word; stream_start restarts position, recent bytes and pending sync marks.
// Output channel (out_valid_o / out_stall_i / out_word_o) gives one word per
// enabled field of a record, in field order, record_last on the final one; a
// record with no enabled field gives one word with field_valid low.
// Configuration (cfg_we_i, cfg_index_i, cfg_data_i) must be written while idle;
// the block itself does not enforce this. Each byte is written into the
// window memory on acceptance; a record is checked at sync position plus the
// end span and its fields are read back one byte per cycle through the single
// window read port. A byte with no sync hit and no due check is done on
// acceptance; a hit or a due check goes on to the mark state, a marked record
// to the clear state, where a dropped record ends, and an outgoing record then
// fetches each enabled field byte by byte, extends it in the tail state and
// sends it from the emit state; a record with no fields goes straight to emit.
// Results sit in an output register, so a new byte is taken while the last
// result waits; a stalled receiver holds the extraction at its next result.
// Reset clears position, recent bytes and the control state; window contents
// are not cleared and no clearing pass is needed, since every slot is
// written in the current stream before it is ever examined.
module sync_word_header_field_extractor #(
  parameter int unsigned WINDOW_BYTES = 512,
  parameter int unsigned FIELD_COUNT  = 3
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  swhfe_pkg::in_word_t                  in_word_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output swhfe_pkg::out_word_t                 out_word_o,
  input  logic                                 cfg_we_i,
  input  logic [swhfe_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [swhfe_pkg::CFG_DATA_W-1:0]     cfg_data_i
);

  localparam int unsigned AW = $clog2(WINDOW_BYTES);
  localparam int unsigned SW = AW + 3;
  localparam logic signed [SW-1:0] W_S = SW'(WINDOW_BYTES);
  localparam logic [AW-1:0] LAST_SLOT = AW'(WINDOW_BYTES - 1);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_MARK  = 6'b000010,
    S_CLR   = 6'b000100,
    S_FETCH = 6'b001000,
    S_TAIL  = 6'b010000,
    S_EMIT  = 6'b100000
  } state_e;

  // Slot arithmetic modulo the window depth
  function automatic logic [AW-1:0] wrap_slot(input logic signed [SW-1:0] x);
    logic signed [SW-1:0] v;
    v = x;
    if (v < 0)    v = v + W_S;
    if (v < 0)    v = v + W_S;
    if (v >= W_S) v = v - W_S;
    if (v >= W_S) v = v - W_S;
    return v[AW-1:0];
  endfunction

  // First enabled field at or after 'from'; MSB flags a hit
  function automatic logic [2:0] first_en(input logic [2:0] en, input logic [2:0] from);
    logic [2:0] r;
    r = 3'b000;
    for (int i = 2; i >= 0; i--) begin
      if (en[i] && (i >= int'(from))) r = {1'b1, 2'(i)};
    end
    return r;
  endfunction

  function automatic logic [63:0] sext(input logic [63:0] v, input logic [1:0] wl,
                                       input logic sg);
    logic [63:0] r;
    unique case (wl)
      2'd0:    r = {{56{sg & v[7]}},  v[7:0]};
      2'd1:    r = {{48{sg & v[15]}}, v[15:0]};
      2'd2:    r = {{32{sg & v[31]}}, v[31:0]};
      default: r = v;
    endcase
    return r;
  endfunction

  swhfe_pkg::cfg_t cfg;

  state_e                      state_q, state_d;
  logic [swhfe_pkg::POS_W-1:0] pos_q, pos_d;
  logic [AW-1:0]               slot_q, slot_d;
  logic [31:0]                 recent_q, recent_d;
  logic                        hit_q, hit_d;
  logic [AW-1:0]               hslot_q, hslot_d;
  logic                        chk_q, chk_d;
  logic [swhfe_pkg::POS_W-1:0] s_q, s_d;
  logic [AW-1:0]               sslot_q, sslot_d;
  logic                        rec_ok_q, rec_ok_d;
  logic [1:0]                  fidx_q, fidx_d;
  logic                        nofield_q, nofield_d;
  logic [2:0]                  k_q, k_d;
  logic [AW-1:0]               raddr_q, raddr_d;
  logic                        rd_pend_q, rd_pend_d;
  logic [63:0]                 acc_q, acc_d;
  logic [63:0]                 val_q, val_d;
  logic                        out_valid_q, out_valid_d;
  swhfe_pkg::out_word_t        out_word_q, out_word_d;
  logic                        out_load;

  logic                        win_we, mark_we, mark_wbit;
  logic [AW-1:0]               win_waddr, win_raddr, mark_waddr, mark_raddr;
  logic [7:0]                  win_rdata;
  logic                        mark_rbit;
  logic [2:0]                  wm1_cur;

  swhfe_cfg #(
    .FieldCount(FIELD_COUNT)
  ) u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .we_i   (cfg_we_i),
    .idx_i  (cfg_index_i),
    .data_i (cfg_data_i),
    .cfg_o  (cfg)
  );

  swhfe_mem #(
    .Depth(WINDOW_BYTES),
    .AW   (AW)
  ) u_mem (
    .clk_i        (clk_i),
    .win_we_i     (win_we),
    .win_waddr_i  (win_waddr),
    .win_wdata_i  (in_word_i.data_byte),
    .win_raddr_i  (win_raddr),
    .win_rdata_o  (win_rdata),
    .mark_we_i    (mark_we),
    .mark_waddr_i (mark_waddr),
    .mark_wbit_i  (mark_wbit),
    .mark_raddr_i (mark_raddr),
    .mark_rbit_o  (mark_rbit)
  );

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;
  assign wm1_cur     = 3'((4'd1 << cfg.wlog[fidx_q]) - 4'd1);

  // Main sequencer: accept, mark update, record check, field fetch, emit
  always_comb begin
    logic [swhfe_pkg::POS_W-1:0] p_eff;
    logic [AW-1:0]               slot_eff;
    logic [31:0]                 rec_eff;
    logic [2:0]                  nf;
    logic [2:0]                  wm1_nf;
    state_d     = state_q;
    pos_d       = pos_q;
    slot_d      = slot_q;
    recent_d    = recent_q;
    hit_d       = hit_q;
    hslot_d     = hslot_q;
    chk_d       = chk_q;
    s_d         = s_q;
    sslot_d     = sslot_q;
    rec_ok_d    = rec_ok_q;
    fidx_d      = fidx_q;
    nofield_d   = nofield_q;
    k_d         = k_q;
    raddr_d     = raddr_q;
    rd_pend_d   = 1'b0;
    acc_d       = rd_pend_q ? {acc_q[55:0], win_rdata} : acc_q;
    val_d       = val_q;
    out_load    = 1'b0;
    out_word_d  = out_word_q;
    win_we      = 1'b0;
    win_waddr   = slot_q;
    win_raddr   = raddr_q;
    mark_we     = 1'b0;
    mark_waddr  = slot_q;
    mark_wbit   = 1'b0;
    mark_raddr  = sslot_q;
    p_eff       = in_word_i.stream_start ? '0 : pos_q;
    slot_eff    = in_word_i.stream_start ? '0 : slot_q;
    rec_eff     = in_word_i.stream_start ? '0 : recent_q;
    nf          = first_en(cfg.en, 3'd0);
    wm1_nf      = '0;

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          pos_d = p_eff;
          if (p_eff != swhfe_pkg::POS_LIMIT) begin
            win_we     = 1'b1;
            win_waddr  = slot_eff;
            mark_we    = 1'b1;
            mark_waddr = slot_eff;
            recent_d   = {rec_eff[23:0], in_word_i.data_byte};
            pos_d      = p_eff + 1'b1;
            slot_d     = (slot_eff == LAST_SLOT) ? '0 : slot_eff + 1'b1;
            hit_d      = (p_eff >= 31'd3) && (recent_d == cfg.pattern);
            hslot_d    = wrap_slot($signed({{(SW-AW){1'b0}}, slot_eff}) - SW'(3));
            chk_d      = (int'(cfg.span) < WINDOW_BYTES) && (p_eff >= {23'b0, cfg.span});
            sslot_d    = wrap_slot($signed({{(SW-AW){1'b0}}, slot_eff})
                                   - $signed({{(SW-8){1'b0}}, cfg.span}));
            mark_raddr = sslot_d;
            s_d        = p_eff - {23'b0, cfg.span};
            if (hit_d || chk_d) state_d = S_MARK;
          end
        end
      end
      S_MARK: begin
        // set this byte's hit; the due mark read has come back
        mark_we    = hit_q;
        mark_waddr = hslot_q;
        mark_wbit  = 1'b1;
        rec_ok_d   = (s_q >= {23'b0, cfg.neg_earliest});
        state_d    = (chk_q && mark_rbit) ? S_CLR : S_IDLE;
      end
      S_CLR: begin
        // consume the mark; drop, emit an empty record or start the first field
        mark_we    = 1'b1;
        mark_waddr = sslot_q;
        mark_wbit  = 1'b0;
        if (!rec_ok_q) begin
          state_d = S_IDLE;
        end else if (!nf[2]) begin
          nofield_d = 1'b1;
          fidx_d    = '0;
          val_d     = '0;
          state_d   = S_EMIT;
        end else begin
          nofield_d = 1'b0;
          fidx_d    = nf[1:0];
          wm1_nf    = 3'((4'd1 << cfg.wlog[nf[1:0]]) - 4'd1);
          raddr_d   = wrap_slot($signed({{(SW-AW){1'b0}}, sslot_q})
                                + $signed({{(SW-8){cfg.off[nf[1:0]][7]}}, cfg.off[nf[1:0]]})
                                + (cfg.big ? SW'(0) : $signed({{(SW-3){1'b0}}, wm1_nf})));
          k_d       = '0;
          acc_d     = '0;
          state_d   = S_FETCH;
        end
      end
      S_FETCH: begin
        win_raddr = raddr_q;
        rd_pend_d = 1'b1;
        k_d       = k_q + 1'b1;
        if (cfg.big) raddr_d = (raddr_q == LAST_SLOT) ? '0 : raddr_q + 1'b1;
        else         raddr_d = (raddr_q == '0) ? LAST_SLOT : raddr_q - 1'b1;
        if (k_q == wm1_cur) state_d = S_TAIL;
      end
      S_TAIL: begin
        val_d   = sext({acc_q[55:0], win_rdata}, cfg.wlog[fidx_q], cfg.sgn[fidx_q]);
        state_d = S_EMIT;
      end
      S_EMIT: begin
        nf = first_en(cfg.en, {1'b0, fidx_q} + 3'd1);
        if (!out_valid_q || !out_stall_i) begin
          out_load                 = 1'b1;
          out_word_d.sync_position = s_q;
          out_word_d.field_index   = fidx_q;
          out_word_d.field_valid   = !nofield_q;
          out_word_d.field_value   = val_q;
          out_word_d.record_last   = nofield_q || !nf[2];
          if (nofield_q || !nf[2]) begin
            state_d = S_IDLE;
          end else begin
            fidx_d  = nf[1:0];
            wm1_nf  = 3'((4'd1 << cfg.wlog[nf[1:0]]) - 4'd1);
            raddr_d = wrap_slot($signed({{(SW-AW){1'b0}}, sslot_q})
                                + $signed({{(SW-8){cfg.off[nf[1:0]][7]}}, cfg.off[nf[1:0]]})
                                + (cfg.big ? SW'(0) : $signed({{(SW-3){1'b0}}, wm1_nf})));
            k_d     = '0;
            acc_d   = '0;
            state_d = S_FETCH;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Output register
  always_comb begin
    if (out_load)         out_valid_d = 1'b1;
    else if (out_stall_i) out_valid_d = out_valid_q;
    else                  out_valid_d = 1'b0;
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      pos_q       <= '0;
      slot_q      <= '0;
      recent_q    <= '0;
      hit_q       <= 1'b0;
      chk_q       <= 1'b0;
      rec_ok_q    <= 1'b0;
      nofield_q   <= 1'b0;
      fidx_q      <= '0;
      k_q         <= '0;
      rd_pend_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      pos_q       <= pos_d;
      slot_q      <= slot_d;
      recent_q    <= recent_d;
      hit_q       <= hit_d;
      chk_q       <= chk_d;
      rec_ok_q    <= rec_ok_d;
      nofield_q   <= nofield_d;
      fidx_q      <= fidx_d;
      k_q         <= k_d;
      rd_pend_q   <= rd_pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    hslot_q    <= hslot_d;
    s_q        <= s_d;
    sslot_q    <= sslot_d;
    raddr_q    <= raddr_d;
    acc_q      <= acc_d;
    val_q      <= val_d;
    out_word_q <= out_word_d;
  end

  a_state_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(state_q))
    else $error("sequencer state not one-hot");

  a_mark_slots_apart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_MARK && hit_q && chk_q) |-> (hslot_q != sslot_q))
    else $error("hit mark written to the slot under check");

  a_last_ends_record: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_load && out_word_d.record_last) |=> (state_q == S_IDLE))
    else $error("record continued after its last word");

  a_fetch_in_field: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FETCH) |-> (k_q <= wm1_cur))
    else $error("byte fetch ran past the field width");

endmodule

@@ dv/tb.sv @@
// Testbench for the sync word header field extractor: scoreboard, stimulus and checking.
module tb;

  localparam int unsigned WIN       = 512;
  localparam int unsigned WDOG_MAX  = 20000;
  localparam int unsigned DRAIN_CYC = 200;

  // Predicts records from accepted bytes and checks output words in order
  class record_board;
    logic [7:0]  win_mem [WIN];
    bit          hit_mark [WIN];
    logic [30:0] pos;
    logic [31:0] recent;
    logic [31:0] sync_val;
    bit          big;
    logic [7:0]  offs [3];
    logic [3:0]  types [3];
    swhfe_pkg::out_word_t pending_q [$];
    int          errors;
    int          bytes_seen;
    int          words_seen;
    int          records_seen;

    function new();
      sync_val = swhfe_pkg::SYNC_RESET;
      big = 1'b1;
      for (int i = 0; i < 3; i++) begin
        offs[i] = '0;
        types[i] = '0;
      end
      pos = '0;
      recent = '0;
      errors = 0;
      bytes_seen = 0;
      words_seen = 0;
      records_seen = 0;
      for (int i = 0; i < WIN; i++) begin
        hit_mark[i] = 1'b0;
        win_mem[i] = '0;
      end
    endfunction

    function int width_of(logic [3:0] t);
      if (t < 1 || t > 8) return 0;
      return 1 << ((t - 1) >> 1);
    endfunction

    function int span_now();
      int span;
      int w;
      span = 4;
      for (int i = 0; i < 3; i++) begin
        w = width_of(types[i]);
        if (w != 0 && 4 + $signed(offs[i]) + w > span) span = 4 + $signed(offs[i]) + w;
      end
      return span & 8'hFF;
    endfunction

    function void write_reg(swhfe_pkg::reg_idx_e idx, logic [31:0] d);
      case (idx)
        swhfe_pkg::REG_SYNC_WORD:  sync_val = d;
        swhfe_pkg::REG_BIG_ENDIAN: big = d[0];
        swhfe_pkg::REG_A_OFFSET:   offs[0] = d[7:0];
        swhfe_pkg::REG_A_TYPE:     types[0] = d[3:0];
        swhfe_pkg::REG_B_OFFSET:   offs[1] = d[7:0];
        swhfe_pkg::REG_B_TYPE:     types[1] = d[3:0];
        swhfe_pkg::REG_C_OFFSET:   offs[2] = d[7:0];
        default:                   types[2] = d[3:0];
      endcase
    endfunction

    function logic [63:0] field_at(longint start, logic [3:0] t);
      int w;
      logic [63:0] v;
      int k;
      w = width_of(t);
      v = '0;
      for (int j = 0; j < w; j++) begin
        k = big ? j : (w - 1 - j);
        v = (v << 8) | 64'(win_mem[(start + k) % WIN]);
      end
      if (t[0] && w < 8 && v[w*8-1]) v = v | ~((64'd1 << (w * 8)) - 1);
      return v;
    endfunction

    // Note one accepted byte and queue any record it completes
    function void note_byte(swhfe_pkg::in_word_t iw);
      logic [31:0] p;
      logic [31:0] pat;
      int span;
      longint s;
      int earliest;
      int n;
      swhfe_pkg::out_word_t ow;
      bytes_seen++;
      if (iw.stream_start) begin
        pos = '0;
        recent = '0;
        for (int i = 0; i < WIN; i++) hit_mark[i] = 1'b0;
      end
      p = pos;
      if (pos == swhfe_pkg::POS_LIMIT) return;
      win_mem[p % WIN] = iw.data_byte;
      hit_mark[p % WIN] = 1'b0;
      recent = (recent << 8) | iw.data_byte;
      pos = pos + 1;
      pat = big ? sync_val : {sync_val[7:0], sync_val[15:8], sync_val[23:16], sync_val[31:24]};
      if (p >= 3 && recent == pat) hit_mark[(p - 3) % WIN] = 1'b1;
      span = span_now();
      if (span >= WIN || p < span) return;
      s = p - span;
      if (!hit_mark[s % WIN]) return;
      hit_mark[s % WIN] = 1'b0;
      earliest = 0;
      for (int i = 0; i < 3; i++)
        if (width_of(types[i]) != 0 && $signed(offs[i]) < earliest) earliest = $signed(offs[i]);
      if (s + earliest < 0) return;
      records_seen++;
      n = 0;
      for (int i = 0; i < 3; i++) begin
        if (width_of(types[i]) == 0) continue;
        ow.sync_position = s[30:0];
        ow.field_index = 2'(i);
        ow.field_valid = 1'b1;
        ow.field_value = field_at(s + $signed(offs[i]), types[i]);
        ow.record_last = 1'b0;
        pending_q.push_back(ow);
        n++;
      end
      if (n == 0) begin
        ow = '0;
        ow.sync_position = s[30:0];
        ow.record_last = 1'b1;
        pending_q.push_back(ow);
      end else begin
        pending_q[$].record_last = 1'b1;
      end
    endfunction

    function void check_word(swhfe_pkg::out_word_t got);
      swhfe_pkg::out_word_t exp_w;
      words_seen++;
      if (pending_q.size() == 0) begin
        $display("%0t: unexpected word %h", $time, got);
        errors++;
        return;
      end
      exp_w = pending_q.pop_front();
      if (got.sync_position !== exp_w.sync_position) begin
        $display("%0t: sync_position exp %0d got %0d", $time, exp_w.sync_position,
                 got.sync_position);
        errors++;
      end
      if (got.field_index !== exp_w.field_index) begin
        $display("%0t: field_index exp %0d got %0d", $time, exp_w.field_index,
                 got.field_index);
        errors++;
      end
      if (got.field_valid !== exp_w.field_valid) begin
        $display("%0t: field_valid exp %0d got %0d", $time, exp_w.field_valid,
                 got.field_valid);
        errors++;
      end
      if (got.field_value !== exp_w.field_value) begin
        $display("%0t: field_value exp %h got %h", $time, exp_w.field_value,
                 got.field_value);
        errors++;
      end
      if (got.record_last !== exp_w.record_last) begin
        $display("%0t: record_last exp %0d got %0d", $time, exp_w.record_last,
                 got.record_last);
        errors++;
      end
    endfunction
  endclass

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_stall;
  swhfe_pkg::in_word_t  in_word;
  logic                 out_valid;
  logic                 out_stall;
  swhfe_pkg::out_word_t out_word;
  logic                 cfg_we;
  logic [2:0]           cfg_index;
  logic [31:0]          cfg_data;

  record_board board;
  int          idle_cycles;
  bit          hold_off;

  sync_word_header_field_extractor dut (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_stall_o(in_stall), .in_word_i(in_word),
    .out_valid_o(out_valid), .out_stall_i(out_stall), .out_word_o(out_word),
    .cfg_we_i(cfg_we), .cfg_index_i(cfg_index), .cfg_data_i(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Sample both channels at the rising edge
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) board.note_byte(in_word);
      if (out_valid && !out_stall) board.check_word(out_word);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
    end
  end

  // Watchdog on cycles with no word moving
  always @(posedge clk) begin
    if (idle_cycles >= WDOG_MAX) begin
      $display("Verification failed");
      $finish;
    end
  end

  // Receiver: random stall per word, or a long hold-off on request
  initial begin
    int gap;
    out_stall = 1'b1;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_off) begin
        out_stall <= 1'b1;
        repeat (150) @(negedge clk);
        hold_off = 1'b0;
      end
      gap = $urandom_range(0, 6);
      if ($urandom_range(0, 3) == 0) gap = 0;
      if (gap != 0) begin
        out_stall <= 1'b1;
        repeat (gap - 1) @(negedge clk);
        @(negedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
    end
  end

  task automatic cfg_write(swhfe_pkg::reg_idx_e idx, logic [31:0] d);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= d;
    board.write_reg(idx, d);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Offer one byte, with a random pre-gap unless told otherwise
  task automatic send_byte(logic [7:0] b, bit start, bit no_gap);
    int gap;
    gap = no_gap ? 0 : $urandom_range(0, 6);
    if (!no_gap && $urandom_range(0, 3) == 0) gap = 0;
    @(negedge clk);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_word <= '{data_byte: b, stream_start: start};
    do @(posedge clk); while (in_stall);
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  // Sync bytes in stream order under the current byte order
  task automatic send_sync(bit no_gap);
    logic [31:0] pat;
    pat = board.big ? board.sync_val :
          {board.sync_val[7:0], board.sync_val[15:8], board.sync_val[23:16],
           board.sync_val[31:24]};
    for (int i = 3; i >= 0; i--) send_byte(pat[i*8 +: 8], 1'b0, no_gap);
  endtask

  task automatic settle();
    while (board.pending_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYC) @(posedge clk);
  endtask

  task automatic random_cfg();
    cfg_write(swhfe_pkg::REG_SYNC_WORD, $urandom());
    cfg_write(swhfe_pkg::REG_BIG_ENDIAN, 32'($urandom_range(0, 1)));
    cfg_write(swhfe_pkg::REG_A_OFFSET, 32'($urandom_range(0, 24) - 8));
    cfg_write(swhfe_pkg::REG_A_TYPE, 32'($urandom_range(0, 15)));
    cfg_write(swhfe_pkg::REG_B_OFFSET, 32'($urandom_range(0, 24) - 8));
    cfg_write(swhfe_pkg::REG_B_TYPE, 32'($urandom_range(0, 9)));
    cfg_write(swhfe_pkg::REG_C_OFFSET, 32'($urandom_range(0, 24) - 8));
    cfg_write(swhfe_pkg::REG_C_TYPE, 32'($urandom_range(0, 8)));
  endtask

  // Stream of well-formed frames with random content, some noise between
  task automatic frames(int n_bytes, bit no_gap);
    int sent;
    sent = 0;
    send_byte(8'($urandom()), 1'b1, no_gap);
    while (sent < n_bytes) begin
      if ($urandom_range(0, 2) != 0) begin
        send_sync(no_gap);
        sent += 4;
      end else begin
        send_byte(8'($urandom()), ($urandom_range(0, 40) == 0), no_gap);
        sent++;
      end
    end
  endtask

  initial begin
    board = new();
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_word = '0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    idle_cycles = 0;
    hold_off = 1'b0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed: reset settings, no field enabled, overlapping syncs
    send_byte(8'hDE, 1'b1, 1'b0);
    send_byte(8'hAD, 1'b0, 1'b0);
    send_sync(1'b0);
    settle();
    cfg_write(swhfe_pkg::REG_SYNC_WORD, 32'hAAAA_AAAA);
    for (int i = 0; i < 8; i++) send_byte(8'hAA, 1'b0, 1'b0);
    send_byte(8'h00, 1'b0, 1'b0);
    settle();

    // Directed: all three fields, negative offset, widest types, little-endian
    cfg_write(swhfe_pkg::REG_SYNC_WORD, 32'h0000_0000);
    cfg_write(swhfe_pkg::REG_SYNC_WORD, 32'hFFFF_FFFF);
    cfg_write(swhfe_pkg::REG_BIG_ENDIAN, 32'd0);
    cfg_write(swhfe_pkg::REG_A_OFFSET, 32'h80);
    cfg_write(swhfe_pkg::REG_A_TYPE, 32'd1);
    cfg_write(swhfe_pkg::REG_B_OFFSET, 32'd4);
    cfg_write(swhfe_pkg::REG_B_TYPE, 32'd7);
    cfg_write(swhfe_pkg::REG_C_OFFSET, 32'h7F);
    cfg_write(swhfe_pkg::REG_C_TYPE, 32'd8);
    send_byte(8'hFF, 1'b1, 1'b0);
    for (int i = 0; i < 3; i++) send_byte(8'hFF, 1'b0, 1'b0);
    settle();

    // Random phases with frames; offsets range from -8 to 16
    for (int ph = 0; ph < 6; ph++) begin
      random_cfg();
      if (ph == 2) hold_off = 1'b1;
      frames(45, ph == 2);
      settle();
    end

    // Wide field reaching back before position zero, then unsigned widths
    cfg_write(swhfe_pkg::REG_BIG_ENDIAN, 32'd1);
    cfg_write(swhfe_pkg::REG_A_OFFSET, 32'hFC);
    cfg_write(swhfe_pkg::REG_A_TYPE, 32'd6);
    cfg_write(swhfe_pkg::REG_B_OFFSET, 32'd0);
    cfg_write(swhfe_pkg::REG_B_TYPE, 32'd4);
    cfg_write(swhfe_pkg::REG_C_OFFSET, 32'd120);
    cfg_write(swhfe_pkg::REG_C_TYPE, 32'd2);
    frames(30, 1'b0);
    settle();

    $display("Run took %0d bytes, %0d records and %0d words checked",
             board.bytes_seen, board.records_seen, board.words_seen);
    $display("covering both byte orders, all field types, offsets and stalls");
    if (board.errors == 0 && board.pending_q.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end
endmodule
